// File: src/mkbp_pkg.sv
// Shared types, code tables and lookup for the Morse keying bit packer.
package mkbp_pkg;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned VBITS_W   = 4;
    localparam int unsigned MAX_BYTES = 6;
    localparam int unsigned CNT_W     = 3;
    localparam int unsigned FILL_W    = 3;
    localparam int unsigned SYM_W     = 22;  // five dashes plus letter gap
    localparam int unsigned WIN_W     = MAX_BYTES * BYTE_W;
    localparam int unsigned NB_W      = 6;   // bit count of one character, up to 40

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    localparam logic [3:0] DASH_BITS = 4'b1110;
    localparam logic [1:0] DOT_BITS  = 2'b10;
    localparam logic [2:0] MAX_SYMS  = 3'd5;
    localparam logic [NB_W-1:0] SPACE_NB = 6'd4;
    localparam logic [NB_W-1:0] BANG_NB  = 6'd40;

    // Upper 3 bits: symbol count; lower 5: symbols, first in the highest used bit, 1 = dash.
    localparam logic [7:0] LETTER_CODES [26] = '{
        8'h41, 8'h88, 8'h8A, 8'h64, 8'h20, 8'h82, 8'h66, 8'h80, 8'h40, 8'h87,
        8'h65, 8'h84, 8'h43, 8'h42, 8'h67, 8'h86, 8'h8D, 8'h62, 8'h60, 8'h21,
        8'h61, 8'h81, 8'h63, 8'h89, 8'h8B, 8'h8C
    };
    localparam logic [7:0] DIGIT_CODES [10] = '{
        8'hBF, 8'hAF, 8'hA7, 8'hA3, 8'hA1, 8'hA0, 8'hB0, 8'hB8, 8'hBC, 8'hBE
    };

    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]                 count;
        logic [FILL_W-1:0]                flush_bits;
        logic                             has_last;
    } burst_t;

    // Return the symbol code of a letter or digit, zero for anything else.
    function automatic logic [7:0] code_lookup(input logic [7:0] c);
        logic [7:0] code;
        logic [7:0] off;
        code = 8'h00;
        off  = 8'h00;
        if (c >= CH_LA && c <= CH_LZ) begin
            off  = c - CH_LA;
            code = LETTER_CODES[off[4:0]];
        end else if (c >= CH_UA && c <= CH_UZ) begin
            off  = c - CH_UA;
            code = LETTER_CODES[off[4:0]];
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            off  = c - CH_ZERO;
            code = DIGIT_CODES[off[3:0]];
        end
        return code;
    endfunction

endpackage

// File: src/mkbp_in_reg.sv
// Input register stage holding one accepted character beat.
module mkbp_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_char,
    output logic       held_last
);

    logic       vld_reg;
    logic [7:0] char_reg;
    logic       last_reg;

    assign s_axis_tready = !vld_reg || advance;
    assign held_valid    = vld_reg;
    assign held_char     = char_reg;
    assign held_last     = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_axis_tready) begin
            vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            char_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
    end

endmodule

// File: src/mkbp_keyer.sv
// Keying logic: expands one character into bits, packs them behind the partial byte.
module mkbp_keyer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           in_char,
    input  logic                 in_last,
    input  logic                 advance,
    output mkbp_pkg::burst_t     burst
);

    logic [7:0]                          acc_reg, acc_next;
    logic [mkbp_pkg::FILL_W-1:0]         fill_reg, fill_next;
    logic                                stopped_reg, stopped_next;

    logic [7:0]                          code;
    logic [2:0]                          nsyms;
    logic [mkbp_pkg::SYM_W-1:0]          sym;
    logic [mkbp_pkg::NB_W-1:0]           nb;
    logic [mkbp_pkg::WIN_W-1:0]          str_l;
    logic [mkbp_pkg::WIN_W-1:0]          window;
    logic [mkbp_pkg::MAX_BYTES-1:0][7:0] win_bytes;
    logic [mkbp_pkg::NB_W-1:0]           total;
    logic [2:0]                          full;
    logic [mkbp_pkg::FILL_W-1:0]         rem;
    logic                                is_alnum;

    always_comb begin
        code     = mkbp_pkg::code_lookup(in_char);
        is_alnum = (code != 8'h00);
        nsyms    = (code[7:5] > mkbp_pkg::MAX_SYMS) ? mkbp_pkg::MAX_SYMS : code[7:5];
        sym      = '0;
        nb       = '0;
        // Build symbols right-aligned, first symbol ends up highest.
        for (int i = 4; i >= 0; i--) begin
            if (3'(i) < nsyms) begin
                if (code[i]) begin
                    sym = {sym[mkbp_pkg::SYM_W-5:0], mkbp_pkg::DASH_BITS};
                    nb  = nb + 6'd4;
                end else begin
                    sym = {sym[mkbp_pkg::SYM_W-3:0], mkbp_pkg::DOT_BITS};
                    nb  = nb + 6'd2;
                end
            end
        end
        sym = {sym[mkbp_pkg::SYM_W-3:0], 2'b00};
        nb  = nb + 6'd2;

        if (stopped_reg || in_char == mkbp_pkg::CH_NUL) begin
            nb = '0;
        end else if (is_alnum) begin
            // keep symbol string
        end else if (in_char == mkbp_pkg::CH_SPACE) begin
            nb = mkbp_pkg::SPACE_NB;
        end else if (in_char == mkbp_pkg::CH_BANG) begin
            nb = mkbp_pkg::BANG_NB - {3'b000, fill_reg};
        end else begin
            nb = '0;
        end

        // Only alphanumerics carry ones; every other case keys zeros.
        if (is_alnum && !stopped_reg) begin
            str_l = {{(mkbp_pkg::WIN_W - mkbp_pkg::SYM_W){1'b0}}, sym}
                    << (6'(mkbp_pkg::WIN_W) - nb);
        end else begin
            str_l = '0;
        end

        window = {acc_reg, {(mkbp_pkg::WIN_W - 8){1'b0}}} | (str_l >> fill_reg);
        // First keyed byte sits at index 0.
        for (int k = 0; k < mkbp_pkg::MAX_BYTES; k++) begin
            win_bytes[k] = window[mkbp_pkg::WIN_W-1-8*k -: 8];
        end
        total     = {3'b000, fill_reg} + nb;
        full      = total[5:3];
        rem       = total[2:0];

        burst.bytes      = win_bytes;
        burst.count      = full + {2'b00, in_last};
        burst.flush_bits = rem;
        burst.has_last   = in_last;

        if (in_last) begin
            acc_next     = '0;
            fill_next    = '0;
            stopped_next = 1'b0;
        end else begin
            acc_next     = win_bytes[full];
            fill_next    = rem;
            stopped_next = stopped_reg || (in_char == mkbp_pkg::CH_NUL);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            fill_reg    <= '0;
            stopped_reg <= 1'b0;
        end else if (advance) begin
            acc_reg     <= acc_next;
            fill_reg    <= fill_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

// File: src/mkbp_emit.sv
// Result register: holds a character's bytes, sends one per cycle unless stalled.
module mkbp_emit (
    input  logic              aclk,
    input  logic              aresetn,
    input  mkbp_pkg::burst_t  burst_in,
    input  logic              load,
    output logic              free,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,
    output logic              m_axis_tlast
);

    mkbp_pkg::burst_t              burst_reg;
    logic [mkbp_pkg::CNT_W-1:0]    cnt_reg;
    logic [mkbp_pkg::CNT_W-1:0]    idx_reg;
    logic [mkbp_pkg::CNT_W-1:0]    sel;
    logic                          final_beat;
    logic [3:0]                    vbits;

    always_comb begin
        sel        = (idx_reg > 3'd5) ? 3'd5 : idx_reg;
        final_beat = burst_reg.has_last && (idx_reg == cnt_reg - 3'd1);
        vbits      = final_beat ? {1'b0, burst_reg.flush_bits} : 4'd8;
        m_axis_tvalid = (idx_reg != cnt_reg);
        m_axis_tdata  = {4'b0000, vbits, burst_reg.bytes[sel]};
        m_axis_tlast  = final_beat;
        free          = !m_axis_tvalid || (m_axis_tready && (idx_reg + 3'd1 == cnt_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else if (load) begin
            cnt_reg <= burst_in.count;
            idx_reg <= '0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            burst_reg <= burst_in;
        end
    end

endmodule

// File: src/morse_keying_bit_packer_top.sv
// Top level of the Morse keying bit packer.
// Input stream: one ASCII character per beat on s_axis_tdata[7:0]; s_axis_tlast marks
// the final character of a message and flushes the partial byte.
// Output stream: one packed byte per beat, first keyed bit in bit 7. m_axis_tdata[11:8]
// gives the count of valid leading bits (8 for full bytes, 0 for the empty end marker);
// m_axis_tlast is high on the final beat of a message.
// A character is held in the input register, is keyed and packed in one pass, and
// its bytes are loaded into the result register, from which they are sent.
// Bytes leave at one per cycle while the receiver is ready. A character produces
// 0 to 3 bytes for letters, digits and space, 5 for '!', and one more when the
// character ends a message (6 at most). Characters that complete no byte are taken
// every cycle while the result register has no bytes left to send.
// When the receiver stalls, the result register holds its beat, the next character
// waits in the input register, and s_axis_tready drops once both are occupied.
// Reset clears the partial byte, the fill count and the stopped flag, and empties
// both registers.
module morse_keying_bit_packer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] character
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] packed_byte, [11:8] valid_bits, rest 0
    output logic        m_axis_tlast    // last_byte
);

    logic             held_valid;
    logic [7:0]       held_char;
    logic             held_last;
    logic             free;
    logic             advance;
    mkbp_pkg::burst_t burst;

    assign advance = held_valid && free;

    mkbp_in_reg u_in_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .advance       (advance),
        .held_valid    (held_valid),
        .held_char     (held_char),
        .held_last     (held_last)
    );

    mkbp_keyer u_keyer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_char (held_char),
        .in_last (held_last),
        .advance (advance),
        .burst   (burst)
    );

    mkbp_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .burst_in      (burst),
        .load          (advance),
        .free          (free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: tb/morse_keying_bit_packer_top_tb.sv
// Testbench for the Morse keying bit packer: directed and random messages, scoreboarded.
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] keyed;
    logic [3:0] nbits;
    logic       fin;
} key_beat_t;

// Tracks the keying state and holds the beats each accepted character should produce.
class keying_scoreboard;
    localparam logic [7:0] CASE_FOLD = 8'h20;

    logic [7:0]  acc;
    int unsigned fill;
    bit          stopped;
    key_beat_t   pending[$];
    int unsigned mismatches;
    int unsigned beats_checked;
    int unsigned chars_noted;
    int unsigned messages;
    int unsigned bangs;
    int unsigned dropped;

    function new();
        clear_stream();
        mismatches    = 0;
        beats_checked = 0;
        chars_noted   = 0;
        messages      = 0;
        bangs         = 0;
        dropped       = 0;
    endfunction

    function void clear_stream();
        acc     = 8'h00;
        fill    = 0;
        stopped = 1'b0;
    endfunction

    function void queue_beat(logic [7:0] b, logic [3:0] n, logic f);
        key_beat_t kb;
        kb.keyed = b;
        kb.nbits = n;
        kb.fin   = f;
        pending.push_back(kb);
    endfunction

    function void push_bit(bit b);
        acc[7 - fill] = b;
        fill++;
        if (fill == 8) begin
            queue_beat(acc, 4'd8, 1'b0);
            acc  = 8'h00;
            fill = 0;
        end
    endfunction

    function void push_zeros(int unsigned n);
        repeat (n) push_bit(1'b0);
    endfunction

    // Dot keys 10, dash keys 1110, and the letter closes with two off bits.
    function void key_pattern(string p);
        for (int i = 0; i < p.len(); i++) begin
            if (p[i] == "-") begin
                push_bit(1'b1);
                push_bit(1'b1);
                push_bit(1'b1);
            end else begin
                push_bit(1'b1);
            end
            push_bit(1'b0);
        end
        push_zeros(2);
    endfunction

    static function string morse_pattern(logic [7:0] ch);
        logic [7:0] c;
        c = ch;
        if (c >= mkbp_pkg::CH_UA && c <= mkbp_pkg::CH_UZ) c = c + CASE_FOLD;
        case (c)
            "a": return ".-";    "b": return "-...";  "c": return "-.-.";
            "d": return "-..";   "e": return ".";     "f": return "..-.";
            "g": return "--.";   "h": return "....";  "i": return "..";
            "j": return ".---";  "k": return "-.-";   "l": return ".-..";
            "m": return "--";    "n": return "-.";    "o": return "---";
            "p": return ".--.";  "q": return "--.-";  "r": return ".-.";
            "s": return "...";   "t": return "-";     "u": return "..-";
            "v": return "...-";  "w": return ".--";   "x": return "-..-";
            "y": return "-.--";  "z": return "--..";
            "0": return "-----"; "1": return ".----"; "2": return "..---";
            "3": return "...--"; "4": return "....-"; "5": return ".....";
            "6": return "-...."; "7": return "--..."; "8": return "---..";
            "9": return "----.";
            default: return "";
        endcase
    endfunction

    function void note_char(logic [7:0] ch, bit last_in);
        string p;
        chars_noted++;
        if (!stopped) begin
            if (ch == mkbp_pkg::CH_NUL) begin
                stopped = 1'b1;
            end else if (ch == mkbp_pkg::CH_SPACE) begin
                push_zeros(4);
            end else if (ch == mkbp_pkg::CH_BANG) begin
                bangs++;
                // pad out to the next byte boundary after the long gap
                push_zeros(32 + 8 - fill);
            end else begin
                p = morse_pattern(ch);
                if (p.len() > 0) key_pattern(p);
                else dropped++;
            end
        end else begin
            dropped++;
        end
        if (last_in) begin
            if (fill != 0) queue_beat(acc, 4'(fill), 1'b1);
            else queue_beat(8'h00, 4'd0, 1'b1);
            clear_stream();
            messages++;
        end
    endfunction

    function void check_beat(logic [7:0] b, logic [3:0] n, logic f);
        key_beat_t kb;
        beats_checked++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected beat byte=%02h bits=%0d last=%0b", b, n, f);
            return;
        end
        kb = pending.pop_front();
        if (kb.keyed !== b || kb.nbits !== n || kb.fin !== f) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"ERROR: beat %0d exp byte=%02h bits=%0d last=%0b,",
                          " got byte=%02h bits=%0d last=%0b"},
                         beats_checked, kb.keyed, kb.nbits, kb.fin, b, n, f);
        end
    endfunction
endclass

module morse_keying_bit_packer_top_tb;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned RANDOM_CHARS = 130;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    keying_scoreboard sb = new();

    int unsigned burst_left = 0;
    int unsigned rx_cnt     = 0;
    int unsigned rx_mode    = 0;
    int unsigned idle_cycles = 0;

    morse_keying_bit_packer_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Note every accepted character and check every accepted byte.
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            sb.note_char(s_axis_tdata, s_axis_tlast);
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata[7:0], m_axis_tdata[11:8], m_axis_tlast);
    end

    // Receiver backpressure: switch at random between stall patterns.
    always @(posedge aclk) begin
        rx_cnt <= rx_cnt + 1;
        if (rx_cnt % 40 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (rx_cnt[1:0] == 2'b00);
            default: m_axis_tready <= (rx_cnt[4:3] != 2'b11);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Send one character; open a new burst after a random gap when the old one runs out.
    task automatic send_char(input logic [7:0] ch, input bit last_in);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 10);
            burst_left = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last_in;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        burst_left--;
    endtask

    // Hold the input until every queued byte has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 8'($urandom_range(0, 25)) +
                   ($urandom_range(0, 1) ? mkbp_pkg::CH_LA : mkbp_pkg::CH_UA);
        else if (r < 65) return mkbp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        else if (r < 78) return mkbp_pkg::CH_SPACE;
        else if (r < 84) return mkbp_pkg::CH_BANG;
        else if (r < 94) return 8'($urandom_range(0, 255));
        return mkbp_pkg::CH_NUL;
    endfunction

    initial begin
        int unsigned sent;
        int unsigned msg_len;
        bit          paused;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // shortest and longest letters, digit extremes, flush on a digit
        send_char("E", 1'b0);
        send_char("t", 1'b0);
        send_char("Z", 1'b0);
        send_char("0", 1'b0);
        send_char("9", 1'b1);
        // unmapped byte, space, then long gap from a partial byte with flush
        send_char("a", 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(mkbp_pkg::CH_SPACE, 1'b0);
        send_char(mkbp_pkg::CH_BANG, 1'b1);
        // long gap from a byte boundary: full bytes, then the empty marker
        send_char(mkbp_pkg::CH_BANG, 1'b1);
        // unmapped character as the last one
        send_char(8'h7F, 1'b1);
        // zero stops the message; later characters key nothing until the flush
        send_char("Q", 1'b0);
        send_char(mkbp_pkg::CH_NUL, 1'b0);
        send_char("M", 1'b0);
        send_char(8'h80, 1'b1);
        send_char(mkbp_pkg::CH_NUL, 1'b1);
        send_char("5", 1'b0);
        send_char("Y", 1'b0);
        send_char("j", 1'b1);
        drain_results();

        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_CHARS) begin
            msg_len = $urandom_range(1, 8);
            for (int i = 0; i < msg_len; i++) begin
                send_char(pick_char(), i == msg_len - 1);
                sent++;
            end
            if ((!paused && sent >= RANDOM_CHARS / 2) || $urandom_range(0, 9) == 0) begin
                drain_results();
                paused = 1'b1;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Keyed %0d characters in %0d messages (%0d long gaps, %0d keyed nothing).",
                 sb.chars_noted, sb.messages, sb.bangs, sb.dropped);
        $display("Checked %0d output beats under varied sender gaps and receiver stalls.",
                 sb.beats_checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("ERROR: %0d mismatches, %0d beats still expected",
                     sb.mismatches, sb.pending.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
